[hdl/slsf_pkg.sv]
// Shared types and constants for the sprite line select and fetch block.
// Holds command and register codes, stream field offsets and the slot record.
// No dependencies.
package slsf_pkg;

    // Command codes carried in s_tuser
    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_OFFER  = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_DECODE = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_OBJECTS_ENABLED = 2'd0,
        REG_TALL_OBJECTS    = 2'd1,
        REG_COLOR_MODE      = 2'd2
    } reg_index_t;

    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 1;

    // Input beat layout (s_tdata), lowest bit first
    localparam int IN_DATA_W   = 72;
    localparam int IN_LINE_LSB = 0;
    localparam int IN_INDEX_LSB = 8;
    localparam int IN_INDEX_W  = 6;
    localparam int IN_Y_LSB    = 14;
    localparam int IN_X_LSB    = 22;
    localparam int IN_TILE_LSB = 30;
    localparam int IN_FLAGS_LSB = 38;
    localparam int IN_PX_LSB   = 46;
    localparam int IN_LOW_LSB  = 54;
    localparam int IN_HIGH_LSB = 62;

    // Output beat layout (m_tdata)
    localparam int OUT_DATA_W = 32;
    localparam int ADDR_W     = 13;

    // Object coordinate offsets and tile pairing mask
    localparam logic [7:0] OBJ_Y_OFFSET   = 8'd16;
    localparam logic [7:0] OBJ_X_OFFSET   = 8'd8;
    localparam logic [7:0] TILE_PAIR_MASK = 8'hFE;
    localparam logic [7:0] SHORT_HEIGHT   = 8'd8;
    localparam logic [7:0] TALL_HEIGHT    = 8'd16;

    // Attribute bits
    localparam int FLAG_BANK  = 3;
    localparam int FLAG_HFLIP = 5;
    localparam int FLAG_VFLIP = 6;
    localparam int FLAG_PRIO  = 7;

    typedef struct packed {
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] tile;
        logic [7:0] flags;
    } slot_t;

endpackage

[hdl/sprite_line_select_fetch.sv]
// Sprite line select and fetch: top level, slot table and shared address unit.
// Depends on slsf_pkg.
//
// Usage:
//   The input stream (s_*) carries one command per beat, the command code in
//   s_tuser. Clear empties the slot table; offer tests one object entry
//   against the scanline and keeps it while slots remain; query walks the
//   held slots and returns one VRAM row fetch beat per slot whose X matches;
//   decode turns two bit-plane bytes into eight pixel beats.
//   The output stream (m_*) carries results; m_tuser is 0 for a fetch request,
//   1 for a decoded pixel, and m_tlast marks the final beat of a command.
//   Clear and offer finish in the cycle they are accepted (one per cycle).
//   An accepted query, with objects enabled and slots held, walks the held
//   slots in an X compare pass, then in an emit pass in which the single
//   address unit forms each row address; with no X match the emit pass is
//   skipped. An accepted decode then emits its eight pixel beats.
//   s_tready is high only while the sequencer is idle.
//   The output register holds a beat until m_tready; the sequencer waits on
//   it and resumes without loss. A stalled last beat does not block new input.
//   Reset clears the slot table, the slot count and all configuration bits.
//   Configuration writes via cfg_we are taken at any time but are meant to
//   land only while the block is idle.
module sprite_line_select_fetch
    import slsf_pkg::*;
#(
    parameter int SLOTS   = 10,
    parameter int ENTRIES = 40
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // line[7:0], entry_index[13:8], entry_y[21:14], entry_x[29:22],
    // entry_tile[37:30], entry_flags[45:38], pixel_x[53:46],
    // tile_low[61:54], tile_high[69:62], zero pad[71:70]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // command[1:0]
    input  logic [CMD_W-1:0]      s_tuser,
    // Output stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // vram_address[12:0], vram_bank[13], sprite_flags[21:14], color_id[23:22],
    // palette[26:24], bg_priority[27], zero pad[31:28]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // kind[0]
    output logic                  m_tuser,
    output logic                  m_tlast,
    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W  = $clog2(SLOTS + 1);
    localparam int ENT_W  = IN_INDEX_W + 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT,
        ST_DECODE
    } state_t;

    state_t               state_reg, state_next;
    slot_t                slot_reg [SLOTS];
    slot_t                slot_next [SLOTS];
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SLOT_W-1:0]    idx_reg, idx_next;
    logic [SLOTS-1:0]     mask_reg, mask_next;
    logic [2:0]           bit_reg, bit_next;

    logic                 obj_en_reg, obj_en_next;
    logic                 tall_reg, tall_next;
    logic                 color_reg, color_next;

    // Latched command operands
    logic [7:0]           line_reg, line_next;
    logic [7:0]           px_reg, px_next;
    logic [7:0]           flags_reg, flags_next;
    logic [7:0]           low_reg, low_next;
    logic [7:0]           high_reg, high_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    logic                 out_kind_reg, out_kind_next;
    logic                 out_last_reg, out_last_next;
    logic [ADDR_W-1:0]    out_addr_reg, out_addr_next;
    logic                 out_bank_reg, out_bank_next;
    logic [7:0]           out_flags_reg, out_flags_next;
    logic [1:0]           out_cid_reg, out_cid_next;
    logic [2:0]           out_pal_reg, out_pal_next;
    logic                 out_pri_reg, out_pri_next;

    // Combinational helpers
    slot_t                cur_slot;
    slot_t                new_slot;
    logic                 out_free;
    logic                 last_slot;
    logic                 higher_hit;
    logic                 match;
    logic [7:0]           height;
    logic [7:0]           row;
    logic [7:0]           tile;
    logic [ADDR_W-1:0]    row_addr;
    logic [7:0]           in_line;
    logic [IN_INDEX_W-1:0] in_index;
    logic [7:0]           in_y;
    logic [7:0]           sy;
    logic [7:0]           offer_row;
    logic [2:0]           sh;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'b0000, out_pri_reg, out_pal_reg, out_cid_reg, out_flags_reg,
                       out_bank_reg, out_addr_reg};

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        mask_next      = mask_reg;
        bit_next       = bit_reg;
        obj_en_next    = obj_en_reg;
        tall_next      = tall_reg;
        color_next     = color_reg;
        line_next      = line_reg;
        px_next        = px_reg;
        flags_next     = flags_reg;
        low_next       = low_reg;
        high_next      = high_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        out_addr_next  = out_addr_reg;
        out_bank_next  = out_bank_reg;
        out_flags_next = out_flags_reg;
        out_cid_next   = out_cid_reg;
        out_pal_next   = out_pal_reg;
        out_pri_next   = out_pri_reg;

        height = tall_reg ? TALL_HEIGHT : SHORT_HEIGHT;

        // Shared address unit: row address of the slot under the cursor
        cur_slot = slot_reg[idx_reg];
        row = line_reg - cur_slot.y;
        if (cur_slot.flags[FLAG_VFLIP])
        begin
            row = (height - 8'd1) - row;
        end
        tile = cur_slot.tile;
        if (tall_reg)
        begin
            tile = tile & TILE_PAIR_MASK;
            if (row >= 8'd8)
            begin
                row  = row - 8'd8;
                tile = tile + 8'd1;
            end
        end
        row_addr = {1'b0, tile, 4'b0000} + {4'b0000, row, 1'b0};

        match     = ((cur_slot.x - OBJ_X_OFFSET) == px_reg);
        last_slot = ((CNT_W'(idx_reg) + CNT_W'(1)) == count_reg);

        // Any later slot still due to emit decides the last flag
        higher_hit = 1'b0;
        for (int k = 0; k < SLOTS; k++)
        begin
            if (k > int'(idx_reg))
            begin
                higher_hit = higher_hit | mask_reg[k];
            end
        end

        // Offer test on the incoming beat
        in_line   = s_tdata[IN_LINE_LSB +: 8];
        in_index  = s_tdata[IN_INDEX_LSB +: IN_INDEX_W];
        in_y      = s_tdata[IN_Y_LSB +: 8];
        sy        = in_y - OBJ_Y_OFFSET;
        offer_row = in_line - sy;
        new_slot.y     = sy;
        new_slot.x     = s_tdata[IN_X_LSB +: 8];
        new_slot.tile  = s_tdata[IN_TILE_LSB +: 8];
        new_slot.flags = s_tdata[IN_FLAGS_LSB +: 8];

        // Pixel order: leftmost first unless flipped
        sh = flags_reg[FLAG_HFLIP] ? bit_reg : ~bit_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_OBJECTS_ENABLED: obj_en_next = cfg_data[0];
                REG_TALL_OBJECTS:    tall_next   = cfg_data[0];
                REG_COLOR_MODE:      color_next  = cfg_data[0];
                default:             ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    line_next  = in_line;
                    px_next    = s_tdata[IN_PX_LSB +: 8];
                    flags_next = s_tdata[IN_FLAGS_LSB +: 8];
                    low_next   = s_tdata[IN_LOW_LSB +: 8];
                    high_next  = s_tdata[IN_HIGH_LSB +: 8];
                    case (s_tuser)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_OFFER:
                        begin
                            if ((ENT_W'(in_index) < ENT_W'(ENTRIES)) &&
                                (count_reg < CNT_W'(SLOTS)) && (offer_row < height))
                            begin
                                slot_next[count_reg[SLOT_W-1:0]] = new_slot;
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_QUERY:
                        begin
                            idx_next  = '0;
                            mask_next = '0;
                            if (obj_en_reg && (count_reg != '0))
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                        CMD_DECODE:
                        begin
                            bit_next   = '0;
                            state_next = ST_DECODE;
                        end
                        default: ;
                    endcase
                end
            end

            ST_SCAN:
            begin
                // One slot X compare per cycle
                mask_next[idx_reg] = match;
                if (last_slot)
                begin
                    idx_next = '0;
                    if ((mask_reg == '0) && !match)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT;
                    end
                end
                else
                begin
                    idx_next = idx_reg + SLOT_W'(1);
                end
            end

            ST_EMIT:
            begin
                // Skip misses at once, hold a hit until the output frees up
                if (!mask_reg[idx_reg] || out_free)
                begin
                    if (mask_reg[idx_reg])
                    begin
                        out_valid_next = 1'b1;
                        out_kind_next  = 1'b0;
                        out_last_next  = !higher_hit;
                        out_addr_next  = row_addr;
                        out_bank_next  = color_reg & cur_slot.flags[FLAG_BANK];
                        out_flags_next = cur_slot.flags;
                        out_cid_next   = '0;
                        out_pal_next   = '0;
                        out_pri_next   = 1'b0;
                    end
                    if (last_slot)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + SLOT_W'(1);
                    end
                end
            end

            ST_DECODE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_kind_next  = 1'b1;
                    out_last_next  = (bit_reg == 3'd7);
                    out_addr_next  = '0;
                    out_bank_next  = 1'b0;
                    out_flags_next = '0;
                    out_cid_next   = {high_reg[sh], low_reg[sh]};
                    out_pal_next   = flags_reg[2:0];
                    out_pri_next   = flags_reg[FLAG_PRIO];
                    bit_next       = bit_reg + 3'd1;
                    if (bit_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            for (int k = 0; k < SLOTS; k++)
            begin
                slot_reg[k] <= '0;
            end
            count_reg     <= '0;
            idx_reg       <= '0;
            mask_reg      <= '0;
            bit_reg       <= '0;
            obj_en_reg    <= 1'b0;
            tall_reg      <= 1'b0;
            color_reg     <= 1'b0;
            line_reg      <= '0;
            px_reg        <= '0;
            flags_reg     <= '0;
            low_reg       <= '0;
            high_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_kind_reg  <= 1'b0;
            out_last_reg  <= 1'b0;
            out_addr_reg  <= '0;
            out_bank_reg  <= 1'b0;
            out_flags_reg <= '0;
            out_cid_reg   <= '0;
            out_pal_reg   <= '0;
            out_pri_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            mask_reg      <= mask_next;
            bit_reg       <= bit_next;
            obj_en_reg    <= obj_en_next;
            tall_reg      <= tall_next;
            color_reg     <= color_next;
            line_reg      <= line_next;
            px_reg        <= px_next;
            flags_reg     <= flags_next;
            low_reg       <= low_next;
            high_reg      <= high_next;
            out_valid_reg <= out_valid_next;
            out_kind_reg  <= out_kind_next;
            out_last_reg  <= out_last_next;
            out_addr_reg  <= out_addr_next;
            out_bank_reg  <= out_bank_next;
            out_flags_reg <= out_flags_next;
            out_cid_reg   <= out_cid_next;
            out_pal_reg   <= out_pal_next;
            out_pri_reg   <= out_pri_next;
        end
    end

endmodule

[test/sprite_line_select_fetch_tb.sv]
// Testbench for sprite_line_select_fetch: drives command beats, predicts every result beat
// and checks the output stream in order. Depends on slsf_pkg and the block itself.
`timescale 1ns / 100ps

module sprite_line_select_fetch_tb;
    import slsf_pkg::*;

    localparam int SLOT_LIMIT  = 10;
    localparam int ENTRY_LIMIT = 40;
    // Settle time after draining, long enough for a silent query to finish
    localparam int HOLD_OFF    = 32;
    localparam int QUIET_LIMIT = 3000;
    localparam int MAX_PRINTED = 40;

    // One command beat, field by field
    typedef struct {
        logic [7:0] line;
        logic [5:0] index;
        logic [7:0] y;
        logic [7:0] x;
        logic [7:0] tile;
        logic [7:0] flags;
        logic [7:0] px;
        logic [7:0] lo;
        logic [7:0] hi;
    } sprite_cmd_t;

    // One result beat, field by field
    typedef struct {
        logic        kind;
        logic [12:0] addr;
        logic        bank;
        logic [7:0]  flags;
        logic [1:0]  cid;
        logic [2:0]  pal;
        logic        pri;
        logic        last;
    } sprite_beat_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted register and slot state
    logic       cfg_objects_on;
    logic       cfg_tall;
    logic       cfg_color;
    logic [7:0] held_y     [SLOT_LIMIT];
    logic [7:0] held_x     [SLOT_LIMIT];
    logic [7:0] held_tile  [SLOT_LIMIT];
    logic [7:0] held_flags [SLOT_LIMIT];
    int         held_count;

    // Fetch requests and pixels still owed by the block, oldest first
    sprite_beat_t due_beats[$];

    int mismatches;
    int quiet_cycles;
    int sender_idle_pct;
    int receiver_stall_pct;

    sprite_line_select_fetch u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Print one line per mismatch (up to a cap) and count them all
    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("%0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Advance the predicted state by one accepted command and queue what it owes
    function automatic void predict_sprite_beats(cmd_t cmd, sprite_cmd_t c);
        sprite_beat_t batch[$];
        sprite_beat_t b;
        logic [7:0]   height;
        logic [7:0]   top;
        logic [7:0]   row;
        logic [7:0]   tile;
        logic [7:0]   shown_x;
        logic [15:0]  addr;
        int           sh;
        height = cfg_tall ? TALL_HEIGHT : SHORT_HEIGHT;
        case (cmd)
            CMD_CLEAR:
            begin
                held_count = 0;
            end
            CMD_OFFER:
            begin
                // Y byte wraps, so objects partly above the top still match
                top = c.y - OBJ_Y_OFFSET;
                row = c.line - top;
                if (c.index < ENTRY_LIMIT && held_count < SLOT_LIMIT && row < height)
                begin
                    held_y[held_count]     = top;
                    held_x[held_count]     = c.x;
                    held_tile[held_count]  = c.tile;
                    held_flags[held_count] = c.flags;
                    held_count++;
                end
            end
            CMD_QUERY:
            begin
                if (cfg_objects_on)
                begin
                    for (int i = 0; i < held_count; i++)
                    begin
                        shown_x = held_x[i] - OBJ_X_OFFSET;
                        if (shown_x == c.px)
                        begin
                            // Row is not bounded here: the query line may differ from the offer
                            row = c.line - held_y[i];
                            if (held_flags[i][FLAG_VFLIP])
                                row = (height - 8'd1) - row;
                            tile = held_tile[i];
                            if (cfg_tall)
                            begin
                                tile = tile & TILE_PAIR_MASK;
                                if (row >= 8'd8)
                                begin
                                    row  = row - 8'd8;
                                    tile = tile + 8'd1;
                                end
                            end
                            addr    = {8'd0, tile} * 16'd16 + {8'd0, row} * 16'd2;
                            b       = '{default: '0};
                            b.addr  = addr[12:0];
                            b.bank  = cfg_color & held_flags[i][FLAG_BANK];
                            b.flags = held_flags[i];
                            batch.push_back(b);
                        end
                    end
                end
            end
            CMD_DECODE:
            begin
                // Leftmost pixel first; horizontal flip reverses the order
                for (int i = 0; i < 8; i++)
                begin
                    sh    = c.flags[FLAG_HFLIP] ? i : 7 - i;
                    b     = '{default: '0};
                    b.kind = 1'b1;
                    b.cid = {c.hi[sh], c.lo[sh]};
                    b.pal = c.flags[2:0];
                    b.pri = c.flags[FLAG_PRIO];
                    batch.push_back(b);
                end
            end
            default:
            begin
            end
        endcase
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[i])
            due_beats.push_back(batch[i]);
    endfunction

    // Send one command beat, with a random idle gap ahead of it; valid stays high on return
    task automatic send_beat(cmd_t cmd, sprite_cmd_t c);
        logic [IN_DATA_W-1:0] d;
        int                   gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct)
            gap++;
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        d = '0;
        d[IN_LINE_LSB  +: 8]          = c.line;
        d[IN_INDEX_LSB +: IN_INDEX_W] = c.index;
        d[IN_Y_LSB     +: 8]          = c.y;
        d[IN_X_LSB     +: 8]          = c.x;
        d[IN_TILE_LSB  +: 8]          = c.tile;
        d[IN_FLAGS_LSB +: 8]          = c.flags;
        d[IN_PX_LSB    +: 8]          = c.px;
        d[IN_LOW_LSB   +: 8]          = c.lo;
        d[IN_HIGH_LSB  +: 8]          = c.hi;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tuser  <= cmd;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_sprite_beats(cmd, c);
    endtask

    // Drop valid and hold until every owed beat is out, then let a silent query finish
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (due_beats.size() != 0)
            @(posedge clk);
        repeat (HOLD_OFF) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_OBJECTS_ENABLED: cfg_objects_on = value;
            REG_TALL_OBJECTS:    cfg_tall       = value;
            REG_COLOR_MODE:      cfg_color      = value;
            default:             ;
        endcase
    endtask

    task automatic write_all_regs(logic objects_on, logic tall, logic color);
        write_reg(REG_OBJECTS_ENABLED, objects_on);
        write_reg(REG_TALL_OBJECTS, tall);
        write_reg(REG_COLOR_MODE, color);
    endtask

    function automatic sprite_cmd_t random_cmd_fields();
        sprite_cmd_t c;
        c.line  = 8'($urandom_range(255));
        c.index = 6'($urandom_range(63));
        c.y     = 8'($urandom_range(255));
        c.x     = 8'($urandom_range(255));
        c.tile  = 8'($urandom_range(255));
        c.flags = 8'($urandom_range(255));
        c.px    = 8'($urandom_range(255));
        c.lo    = 8'($urandom_range(255));
        c.hi    = 8'($urandom_range(255));
        return c;
    endfunction

    // Decode at reset config: plain, all flag bits set, flipped with a mixed pattern
    task automatic test_decode_rows();
        sprite_cmd_t c;
        c = random_cmd_fields();
        c.flags = 8'h00; c.lo = 8'hFF; c.hi = 8'h00;
        send_beat(CMD_DECODE, c);
        c.flags = 8'hFF; c.lo = 8'h0F; c.hi = 8'hF0;
        send_beat(CMD_DECODE, c);
        c.flags = 8'h27; c.lo = 8'hA5; c.hi = 8'h3C;
        send_beat(CMD_DECODE, c);
        // Objects still disabled from reset: expect nothing back
        send_beat(CMD_QUERY, c);
        drain_results();
    endtask

    // Index limit, height test across the top edge, vertical flip and bank select
    task automatic test_offer_rules();
        sprite_cmd_t c;
        write_all_regs(1'b1, 1'b0, 1'b1);
        c = random_cmd_fields();
        c.line = 8'd0;
        send_beat(CMD_CLEAR, c);
        c.index = 6'd63; c.y = 8'd16; c.x = 8'd8;
        send_beat(CMD_OFFER, c);
        c.index = 6'd40;
        send_beat(CMD_OFFER, c);
        // Seven rows above the top, last row visible on line 0
        c.index = 6'd39; c.y = 8'd9; c.x = 8'd0; c.tile = 8'h5A; c.flags = 8'h48;
        send_beat(CMD_OFFER, c);
        // One row past the bottom edge: rejected
        c.index = 6'd0; c.y = 8'd8;
        send_beat(CMD_OFFER, c);
        c.index = 6'd1; c.y = 8'd16; c.x = 8'd8; c.tile = 8'hFF; c.flags = 8'h00;
        send_beat(CMD_OFFER, c);
        c.px = 8'd248;
        send_beat(CMD_QUERY, c);
        c.px = 8'd0;
        send_beat(CMD_QUERY, c);
        // Query far from the offer line: row runs unbounded
        c.line = 8'd200;
        send_beat(CMD_QUERY, c);
        drain_results();
    endtask

    // Eleven matching offers on the last line: only ten held, all emitted in order
    task automatic test_table_full();
        sprite_cmd_t c;
        c = random_cmd_fields();
        c.line = 8'd255;
        send_beat(CMD_CLEAR, c);
        for (int i = 0; i <= SLOT_LIMIT; i++)
        begin
            c.index = 6'(i * 3);
            c.y     = 8'd15;
            c.x     = 8'd255;
            c.tile  = 8'(i * 25);
            c.flags = 8'(i * 23);
            send_beat(CMD_OFFER, c);
        end
        c.px = 8'd247;
        send_beat(CMD_QUERY, c);
        drain_results();
    endtask

    // Tall objects with tile pairing and vertical flip, then display disabled
    task automatic test_tall_rows_and_disable();
        sprite_cmd_t c;
        write_all_regs(1'b1, 1'b1, 1'b1);
        c = random_cmd_fields();
        c.line = 8'd20;
        send_beat(CMD_CLEAR, c);
        c.index = 6'd5; c.y = 8'd28; c.x = 8'd100; c.tile = 8'h11; c.flags = 8'h08;
        send_beat(CMD_OFFER, c);
        c.index = 6'd6; c.y = 8'd36; c.tile = 8'hFF; c.flags = 8'h40;
        send_beat(CMD_OFFER, c);
        c.px = 8'd92;
        send_beat(CMD_QUERY, c);
        drain_results();
        write_reg(REG_OBJECTS_ENABLED, 1'b0);
        send_beat(CMD_QUERY, c);
        drain_results();
    endtask

    // Mostly well-formed scanlines: clear, offers near the line, matching queries, decodes;
    // the rest is fully random noise
    task automatic test_random_traffic(int item_goal);
        sprite_cmd_t c;
        logic [7:0]  xs[$];
        logic [7:0]  height;
        int          sent;
        int          n_offers;
        int          n_queries;
        sent = 0;
        write_all_regs($urandom_range(4) != 0, 1'($urandom_range(1)), 1'($urandom_range(1)));
        while (sent < item_goal)
        begin
            if ($urandom_range(3) == 0)
            begin
                drain_results();
                write_all_regs($urandom_range(4) != 0, 1'($urandom_range(1)),
                               1'($urandom_range(1)));
            end
            if ($urandom_range(99) < 15)
            begin
                c = random_cmd_fields();
                send_beat(cmd_t'($urandom_range(3)), c);
                sent++;
            end
            else
            begin
                xs.delete();
                height = cfg_tall ? TALL_HEIGHT : SHORT_HEIGHT;
                c = random_cmd_fields();
                send_beat(CMD_CLEAR, c);
                sent++;
                n_offers = $urandom_range(14);
                for (int i = 0; i < n_offers; i++)
                begin
                    c.index = ($urandom_range(9) != 0) ? 6'($urandom_range(ENTRY_LIMIT - 1))
                                                       : 6'($urandom_range(63, ENTRY_LIMIT));
                    if ($urandom_range(4) != 0)
                        c.y = c.line + OBJ_Y_OFFSET - 8'($urandom_range(height - 1));
                    else
                        c.y = 8'($urandom_range(255));
                    if (xs.size() > 0 && $urandom_range(1) == 0)
                        c.x = xs[$urandom_range(xs.size() - 1)];
                    else
                        c.x = 8'($urandom_range(255));
                    xs.push_back(c.x);
                    c.tile  = 8'($urandom_range(255));
                    c.flags = 8'($urandom_range(255));
                    send_beat(CMD_OFFER, c);
                    sent++;
                end
                n_queries = $urandom_range(6, 1);
                for (int i = 0; i < n_queries; i++)
                begin
                    if (xs.size() > 0 && $urandom_range(3) != 0)
                        c.px = xs[$urandom_range(xs.size() - 1)] - OBJ_X_OFFSET;
                    else
                        c.px = 8'($urandom_range(255));
                    if ($urandom_range(6) == 0)
                        c.line = 8'($urandom_range(255));
                    send_beat(CMD_QUERY, c);
                    sent++;
                    if ($urandom_range(2) == 0)
                    begin
                        c.flags = 8'($urandom_range(255));
                        c.lo    = 8'($urandom_range(255));
                        c.hi    = 8'($urandom_range(255));
                        send_beat(CMD_DECODE, c);
                        sent++;
                    end
                end
            end
        end
        drain_results();
    endtask

    // Receiver: stall at random per the current phase
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);

    // Compare every accepted result beat with the oldest owed one
    always @(posedge clk)
    begin
        sprite_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_beats.size() == 0)
                report_mismatch("result beat with nothing pending", m_tdata, 32'd0);
            else
            begin
                want = due_beats.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", 32'(m_tuser), 32'(want.kind));
                if (m_tdata[ADDR_W-1:0] !== want.addr)
                    report_mismatch("vram_address", 32'(m_tdata[ADDR_W-1:0]),
                                    32'(want.addr));
                if (m_tdata[13] !== want.bank)
                    report_mismatch("vram_bank", 32'(m_tdata[13]), 32'(want.bank));
                if (m_tdata[21:14] !== want.flags)
                    report_mismatch("sprite_flags", 32'(m_tdata[21:14]), 32'(want.flags));
                if (m_tdata[23:22] !== want.cid)
                    report_mismatch("color_id", 32'(m_tdata[23:22]), 32'(want.cid));
                if (m_tdata[26:24] !== want.pal)
                    report_mismatch("palette", 32'(m_tdata[26:24]), 32'(want.pal));
                if (m_tdata[27] !== want.pri)
                    report_mismatch("bg_priority", 32'(m_tdata[27]), 32'(want.pri));
                if (m_tdata[31:28] !== 4'd0)
                    report_mismatch("tdata pad", 32'(m_tdata[31:28]), 32'd0);
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
        else
            quiet_cycles++;
    end

    initial
    begin
        rst_n              = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = CMD_CLEAR;
        m_tready           = 1'b1;
        cfg_we             = 1'b0;
        cfg_index          = REG_OBJECTS_ENABLED;
        cfg_data           = '0;
        cfg_objects_on     = 1'b0;
        cfg_tall           = 1'b0;
        cfg_color          = 1'b0;
        held_count         = 0;
        mismatches         = 0;
        quiet_cycles       = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_decode_rows();
        test_offer_rules();
        test_table_full();
        test_tall_rows_and_disable();

        // Random traffic under each idle pattern
        test_random_traffic(90);
        sender_idle_pct = 68;
        test_random_traffic(90);
        sender_idle_pct    = 0;
        receiver_stall_pct = 68;
        test_random_traffic(90);
        sender_idle_pct    = 30;
        receiver_stall_pct = 30;
        test_random_traffic(90);

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
